>>> sv/pcq_pkg.sv
// ----------------------------------------------------------------------------
// pcq_pkg
// Types and constants shared by the pedal cadence qualifier modules.
// ----------------------------------------------------------------------------
package pcq_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned DUR_W     = 16;
	localparam int unsigned FACTOR_W  = 8;
	localparam int unsigned PROD_W    = 23;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned DIGIT_W   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_DUAL_HALL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_LIM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd3;

	localparam logic [DUR_W-1:0]    TIMEOUT_RST    = 16'd500;
	localparam logic [FACTOR_W-1:0] FACTOR_LIM_RST = 8'd150;
	localparam logic [FACTOR_W-1:0] DEBOUNCE_RST   = 8'd5;

	localparam logic [6:0]          DUTY_SCALE = 7'd100;
	localparam logic [FACTOR_W-1:0] DUTY_MAX   = 8'd200;
	localparam logic [FACTOR_W-1:0] SMOOTH_MAX = 8'd255;

	localparam logic [0:0] CMD_CHANGE = 1'b0;
	localparam logic [0:0] CMD_TICK   = 1'b1;

	typedef struct packed {
		logic [0:0]        cmd;
		logic [TIME_W-1:0] now_ms;
		logic              pin_level;
	} in_item_t;

	typedef struct packed {
		logic                pedaling;
		logic [FACTOR_W-1:0] duty_factor;
		logic [FACTOR_W-1:0] filtered_factor;
		logic [DUR_W-1:0]    period_ms;
	} out_item_t;

endpackage

>>> sv/pcq_serial_sub.sv
// ----------------------------------------------------------------------------
// pcq_serial_sub
// Digit-serial 32-bit subtractor, one 4-bit digit per cycle, LSB first.
// ----------------------------------------------------------------------------
module pcq_serial_sub (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pcq_pkg::TIME_W-1:0]   a,
	input  logic [pcq_pkg::TIME_W-1:0]   b,
	output logic                         done,
	output logic [pcq_pkg::TIME_W-1:0]   diff
);

	localparam int unsigned NDIG  = pcq_pkg::TIME_W / pcq_pkg::DIGIT_W;
	localparam int unsigned CNT_W = $clog2(NDIG);

	logic [pcq_pkg::TIME_W-1:0]  a_q;
	logic [pcq_pkg::TIME_W-1:0]  b_q;
	logic [pcq_pkg::TIME_W-1:0]  res_q;
	logic                        carry_q;
	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [pcq_pkg::DIGIT_W:0]   dsum;

	assign dsum = {1'b0, a_q[pcq_pkg::DIGIT_W-1:0]}
		+ {1'b0, ~b_q[pcq_pkg::DIGIT_W-1:0]}
		+ {{pcq_pkg::DIGIT_W{1'b0}}, carry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q     <= a;
			b_q     <= b;
			carry_q <= 1'b1;
		end else if (busy_q) begin
			a_q     <= a_q >> pcq_pkg::DIGIT_W;
			b_q     <= b_q >> pcq_pkg::DIGIT_W;
			carry_q <= dsum[pcq_pkg::DIGIT_W];
			res_q   <= {dsum[pcq_pkg::DIGIT_W-1:0],
				res_q[pcq_pkg::TIME_W-1:pcq_pkg::DIGIT_W]};
		end
	end

	assign done = done_q;
	assign diff = res_q;

endmodule

>>> sv/pcq_divider.sv
// ----------------------------------------------------------------------------
// pcq_divider
// Restoring divider, one quotient bit per cycle, result clamped at 200.
// ----------------------------------------------------------------------------
module pcq_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pcq_pkg::PROD_W-1:0]     dividend,
	input  logic [pcq_pkg::DUR_W-1:0]      divisor,
	output logic                           done,
	output logic [pcq_pkg::FACTOR_W-1:0]   quotient
);

	localparam int unsigned QW    = pcq_pkg::FACTOR_W;
	localparam int unsigned DW    = pcq_pkg::DUR_W;
	localparam int unsigned CNT_W = $clog2(QW);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [QW-1:0]    dlo_q;
	logic [QW-1:0]    quo_q;
	logic             ovf_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW:0]      trial;
	logic [DW:0]      trial_sub;
	logic             ge;

	assign trial     = {rem_q, dlo_q[QW-1]};
	assign ge        = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(dividend[pcq_pkg::PROD_W-1:QW]);
			dvs_q <= divisor;
			dlo_q <= dividend[QW-1:0];
			ovf_q <= {1'b0, dividend[pcq_pkg::PROD_W-1:QW]} >= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			dlo_q <= dlo_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = (ovf_q || quo_q > pcq_pkg::DUTY_MAX) ? pcq_pkg::DUTY_MAX : quo_q;

endmodule

>>> sv/pedal_cadence_qualifier.sv
// ----------------------------------------------------------------------------
// pedal_cadence_qualifier
// Pedal-assist hall sensor qualifier: debounce, period, duty factor, filter.
// ----------------------------------------------------------------------------
// One item in gives one result. The elapsed time since the last accepted
// change is formed by a 4-bit-per-cycle serial subtractor, and in
// single-hall mode the duty factor by a 1-bit-per-cycle restoring divider
// after a registered multiply. A tick, a debounced change or a dual-hall
// change passes through S_SUB, S_EVAL and S_DONE; a single-hall change also
// goes through S_MUL, S_DIV and S_FILT before S_DONE. An item leaves S_DONE
// only once the output register is free, and the next item is taken in S_IDLE.
// A finished result waits in the output register, so the next item is taken
// while it is pending. The user must write configuration only while no
// item is in flight; the block itself does not enforce this.
module pedal_cadence_qualifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pcq_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pcq_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  logic [pcq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcq_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SUB  = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_DIV  = 7'b0010000,
		S_FILT = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic                           dual_q;
	logic [pcq_pkg::DUR_W-1:0]      timeout_q;
	logic [pcq_pkg::FACTOR_W-1:0]   limit_q;
	logic [pcq_pkg::FACTOR_W-1:0]   debounce_q;

	// block state
	logic [pcq_pkg::TIME_W-1:0]     last_q;
	logic [pcq_pkg::DUR_W-1:0]      high_q;
	logic [pcq_pkg::DUR_W-1:0]      low_q;
	logic [pcq_pkg::DUR_W-1:0]      psum_q;
	logic                           level_q;
	logic [pcq_pkg::FACTOR_W-1:0]   raw_q;
	logic [pcq_pkg::DUR_W-1:0]      accum_q;
	logic [pcq_pkg::FACTOR_W-1:0]   smooth_q;
	logic                           pedal_q;

	// item in flight
	pcq_pkg::in_item_t              item_q;
	logic [pcq_pkg::PROD_W-1:0]     prod_q;
	logic                           div_start_q;

	// output register
	logic                           out_valid_q;
	pcq_pkg::out_item_t             out_q;

	logic                           sub_start;
	logic                           sub_done;
	logic [pcq_pkg::TIME_W-1:0]     since;
	logic                           div_done;
	logic [pcq_pkg::FACTOR_W-1:0]   quot;

	logic [pcq_pkg::DUR_W-1:0]      elapsed;
	logic [pcq_pkg::DUR_W-1:0]      new_low;
	logic [pcq_pkg::DUR_W-1:0]      new_high;
	logic [pcq_pkg::DUR_W-1:0]      new_psum;
	logic                           too_soon;
	logic                           timed_out;
	logic [pcq_pkg::DUR_W-1:0]      accum_new;
	logic [pcq_pkg::DUR_W-2:0]      half;
	logic [pcq_pkg::FACTOR_W-1:0]   smooth_new;
	logic                           out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign sub_start = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign elapsed   = since[pcq_pkg::DUR_W-1:0];
	assign new_low   = item_q.pin_level ? elapsed : low_q;
	assign new_high  = item_q.pin_level ? high_q : elapsed;
	assign new_psum  = new_low + new_high;
	assign too_soon  = since < {{(pcq_pkg::TIME_W - pcq_pkg::FACTOR_W){1'b0}}, debounce_q};
	assign timed_out = since > {{(pcq_pkg::TIME_W - pcq_pkg::DUR_W){1'b0}}, timeout_q};

	assign accum_new  = accum_q + {8'd0, raw_q} - {8'd0, smooth_q};
	assign half       = accum_new[pcq_pkg::DUR_W-1:1];
	assign smooth_new = (half > {7'd0, pcq_pkg::SMOOTH_MAX}) ? pcq_pkg::SMOOTH_MAX
		: half[pcq_pkg::FACTOR_W-1:0];

	pcq_serial_sub u_sub (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sub_start),
		.a      (in_item.now_ms),
		.b      (last_q),
		.done   (sub_done),
		.diff   (since)
	);

	pcq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (low_q),
		.done     (div_done),
		.quotient (quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dual_q     <= 1'b0;
			timeout_q  <= pcq_pkg::TIMEOUT_RST;
			limit_q    <= pcq_pkg::FACTOR_LIM_RST;
			debounce_q <= pcq_pkg::DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcq_pkg::CFG_DUAL_HALL:  dual_q     <= cfg_wdata[0];
				pcq_pkg::CFG_TIMEOUT:    timeout_q  <= cfg_wdata;
				pcq_pkg::CFG_FACTOR_LIM: limit_q    <= cfg_wdata[pcq_pkg::FACTOR_W-1:0];
				pcq_pkg::CFG_DEBOUNCE:   debounce_q <= cfg_wdata[pcq_pkg::FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sub_start) begin
			item_q <= in_item;
		end
		if (state_q == S_MUL) begin
			prod_q <= pcq_pkg::PROD_W'(high_q) * pcq_pkg::PROD_W'(pcq_pkg::DUTY_SCALE);
		end
		if (state_q == S_DONE && out_free) begin
			out_q.pedaling        <= pedal_q;
			out_q.duty_factor     <= raw_q;
			out_q.filtered_factor <= smooth_q;
			out_q.period_ms       <= psum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			high_q      <= '0;
			low_q       <= '0;
			psum_q      <= '0;
			level_q     <= 1'b0;
			raw_q       <= '0;
			accum_q     <= '0;
			smooth_q    <= '0;
			pedal_q     <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sub_start) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					if (sub_done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_DONE;
					if (item_q.cmd == pcq_pkg::CMD_TICK) begin
						if (timed_out) begin
							pedal_q  <= 1'b0;
							raw_q    <= '0;
							smooth_q <= '0;
						end
					end else if (!too_soon) begin
						level_q <= item_q.pin_level;
						last_q  <= item_q.now_ms;
						high_q  <= new_high;
						psum_q  <= new_psum;
						if (dual_q) begin
							low_q   <= new_low;
							pedal_q <= (new_psum <= timeout_q);
						end else begin
							low_q   <= (new_low == '0) ? pcq_pkg::DUR_W'(1) : new_low;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						raw_q   <= quot;
						state_q <= S_FILT;
					end
				end
				S_FILT: begin
					accum_q  <= accum_new;
					smooth_q <= smooth_new;
					pedal_q  <= (psum_q <= timeout_q) && (smooth_new < limit_q);
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> sv/pcq_checker.sv
// ----------------------------------------------------------------------------
// pcq_checker
// Port-level checks on the pedal cadence qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module pcq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input pcq_pkg::out_item_t            out_item
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("pending result changed");

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while busy");

	// a new result only appears while the input side is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without item");

	// duty factor clamp
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.duty_factor <= pcq_pkg::DUTY_MAX)
		else $error("duty factor above clamp");

endmodule

bind pedal_cadence_qualifier pcq_checker u_pcq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
